// ===== rtl/core/qvr_pkg.sv =====
package qvr_pkg;

  // Side flags that travel with one item through the divider stages.
  typedef struct packed {
    logic       zero;
    logic [2:0] neg;
  } qvr_flags_t;

endpackage

// ===== rtl/core/quaternion_vector_rotation.sv =====
// Rotates a vector v by a quaternion q that need not have unit length, as the vector part
// of q*(v,0)*conj(q)/|q|^2. The quaternion is signed Q1.14 and the vector and the result are
// signed Q7.8 at the default widths. Each result component is the exact quotient rounded to
// nearest with ties away from zero, then saturated to the vector range. A zero quaternion
// gives a zero vector with zero_quat set in tuser. The block takes one item per clock cycle
// while the master side does not stall. The pipeline has five arithmetic stages, one
// restoring division stage per result bit, and the output register. A stall on the master
// side holds the whole pipeline.
module quaternion_vector_rotation
  import qvr_pkg::*;
#(
  parameter int QUAT_WIDTH = 16,
  parameter int VEC_WIDTH  = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // From bit 0: vec_x, vec_y, vec_z, quat_x, quat_y, quat_z, quat_w, zero fill.
  input  logic [((3*VEC_WIDTH+4*QUAT_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // From bit 0: rot_x, rot_y, rot_z, zero fill.
  output logic [((3*VEC_WIDTH+7)/8)*8-1:0] m_axis_tdata_o,
  // Bit 0: zero_quat.
  output logic m_axis_tuser_o
);

  localparam int QW   = QUAT_WIDTH;
  localparam int VW   = VEC_WIDTH;
  localparam int PQW  = 2*QW;
  localparam int PVW  = QW+VW;
  localparam int SW   = 2*QW+2;
  localparam int MW   = QW+VW+2;
  localparam int TSW  = SW+VW;
  localparam int TDW  = MW+QW;
  localparam int NUMW = 2*QW+VW+5;
  localparam int AW   = NUMW+1;
  localparam int DW   = 2*QW+3;
  localparam int OTW  = ((3*VW+7)/8)*8;

  logic en;
  assign en = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // Input field extraction.
  logic signed [VW-1:0] vin [3];
  logic signed [QW-1:0] qin [3];
  logic signed [QW-1:0] win;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      vin[c] = s_axis_tdata_i[c*VW +: VW];
      qin[c] = s_axis_tdata_i[3*VW + c*QW +: QW];
    end
    win = s_axis_tdata_i[3*VW + 3*QW +: QW];
  end

  // Stage 1: squares of the quaternion and all quaternion-vector products.
  logic               v1_q;
  logic signed [PQW-1:0] sq1_q [3];
  logic signed [PQW-1:0] ww1_q;
  logic signed [PVW-1:0] qv1_q [3][3];
  logic signed [VW-1:0]  v1d_q [3];
  logic signed [QW-1:0]  q1d_q [3];
  logic signed [QW-1:0]  w1d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        sq1_q[c] <= qin[c] * qin[c];
        v1d_q[c] <= vin[c];
        q1d_q[c] <= qin[c];
        for (int j = 0; j < 3; j++) begin
          qv1_q[c][j] <= qin[c] * vin[j];
        end
      end
      ww1_q <= win * win;
      w1d_q <= win;
    end
  end

  // Stage 2: norm, scalar term, dot product and cross product.
  logic                v2_q;
  logic signed [SW-1:0] n2_q, s2_q;
  logic signed [MW-1:0] d2_q;
  logic signed [MW-1:0] c2_q [3];
  logic signed [VW-1:0] v2d_q [3];
  logic signed [QW-1:0] q2d_q [3];
  logic signed [QW-1:0] w2d_q;
  logic signed [SW-1:0] uu;

  assign uu = SW'(sq1_q[0]) + SW'(sq1_q[1]) + SW'(sq1_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n2_q    <= SW'(ww1_q) + uu;
      s2_q    <= SW'(ww1_q) - uu;
      d2_q    <= (MW'(qv1_q[0][0]) + MW'(qv1_q[1][1]) + MW'(qv1_q[2][2])) <<< 1;
      c2_q[0] <= MW'(qv1_q[1][2]) - MW'(qv1_q[2][1]);
      c2_q[1] <= MW'(qv1_q[2][0]) - MW'(qv1_q[0][2]);
      c2_q[2] <= MW'(qv1_q[0][1]) - MW'(qv1_q[1][0]);
      v2d_q   <= v1d_q;
      q2d_q   <= q1d_q;
      w2d_q   <= w1d_q;
    end
  end

  // Stage 3: the three numerator terms per component.
  logic                 v3_q;
  logic signed [SW-1:0]  n3_q;
  logic signed [TSW-1:0] ts3_q [3];
  logic signed [TDW-1:0] td3_q [3];
  logic signed [TDW-1:0] tc3_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n3_q <= n2_q;
      for (int c = 0; c < 3; c++) begin
        ts3_q[c] <= s2_q * v2d_q[c];
        td3_q[c] <= d2_q * q2d_q[c];
        tc3_q[c] <= c2_q[c] * w2d_q;
      end
    end
  end

  // Stage 4: numerator sums.
  logic                  v4_q;
  logic signed [SW-1:0]   n4_q;
  logic signed [NUMW-1:0] num4_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n4_q <= n3_q;
      for (int c = 0; c < 3; c++) begin
        num4_q[c] <= NUMW'(ts3_q[c]) + NUMW'(td3_q[c]) + (NUMW'(tc3_q[c]) <<< 1);
      end
    end
  end

  // Stage 5: rounding offset, divisor and the saturation check.
  logic [NUMW-1:0] mag [3];
  logic [AW-1:0]   dvd [3];
  logic [DW-1:0]   dvs;
  logic [2:0]      neg5;
  logic [2:0]      ovf5;

  always_comb begin
    dvs = {n4_q[DW-2:0], 1'b0};
    for (int c = 0; c < 3; c++) begin
      neg5[c] = num4_q[c][NUMW-1];
      mag[c]  = neg5[c] ? NUMW'(-num4_q[c]) : NUMW'(num4_q[c]);
      dvd[c]  = {mag[c], 1'b0} + AW'(unsigned'(n4_q));
      ovf5[c] = dvd[c] >= (AW'(dvs) << VW);
    end
  end

  // Division pipeline: entry 0 is stage 5, entry k+1 has quotient bit VW-1-k settled.
  logic            vld_q [VW+1];
  qvr_flags_t      fl_q  [VW+1];
  logic [AW-1:0]   rem_q [VW+1][3];
  logic [VW-1:0]   quo_q [VW+1][3];
  logic [DW-1:0]   dvs_q [VW+1];
  logic [2:0]      ovf_q [VW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fl_q[0].zero <= (n4_q == '0);
      fl_q[0].neg  <= neg5;
      ovf_q[0]     <= ovf5;
      dvs_q[0]     <= dvs;
      for (int c = 0; c < 3; c++) begin
        rem_q[0][c] <= dvd[c];
        quo_q[0][c] <= '0;
      end
    end
  end

  for (genvar k = 0; k < VW; k++) begin : g_div
    localparam int SH = VW-1-k;
    logic [AW-1:0] sub [3];
    logic [2:0]    ge;

    // One restoring step per component.
    always_comb begin
      for (int c = 0; c < 3; c++) begin
        sub[c] = AW'(dvs_q[k]) << SH;
        ge[c]  = rem_q[k][c] >= sub[c];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        fl_q[k+1]      <= fl_q[k];
        ovf_q[k+1]     <= ovf_q[k];
        dvs_q[k+1]     <= dvs_q[k];
        for (int c = 0; c < 3; c++) begin
          rem_q[k+1][c] <= ge[c] ? rem_q[k][c] - sub[c] : rem_q[k][c];
          quo_q[k+1][c] <= {quo_q[k][c][VW-2:0], ge[c]};
        end
      end
    end
  end

  // Output stage: sign, saturation and zero quaternion forcing.
  localparam logic [VW-1:0] LIM  = {1'b1, {(VW-1){1'b0}}};
  localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};

  logic [VW-1:0] rot_d [3];
  logic [VW-1:0] rot_q [3];
  logic          zq_q;
  logic          ov_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (fl_q[VW].zero) begin
        rot_d[c] = '0;
      end else if (fl_q[VW].neg[c]) begin
        rot_d[c] = (ovf_q[VW][c] || quo_q[VW][c] > LIM) ? LIM : VW'(-quo_q[VW][c]);
      end else begin
        rot_d[c] = (ovf_q[VW][c] || quo_q[VW][c] >= LIM) ? VMAX : quo_q[VW][c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en) begin
      ov_q <= vld_q[VW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rot_q <= rot_d;
      zq_q  <= fl_q[VW].zero;
    end
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tuser_o  = zq_q;
  assign m_axis_tdata_o  = OTW'({rot_q[2], rot_q[1], rot_q[0]});

endmodule
